FILE: hw/rtl/a64dp_pkg.sv
`timescale 1ns / 1ps

package a64dp_pkg;

    localparam int XLEN     = 64;
    localparam int HALF     = 32;
    localparam int NUM_REGS = 31;
    localparam int REG_AW   = 5;

    localparam logic [REG_AW-1:0] ZERO_REG = 5'd31;

    // Instruction class
    localparam logic [1:0] CMD_LOGIC  = 2'd0;
    localparam logic [1:0] CMD_ADDSUB = 2'd1;

    // Shift applied to Rm
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // Logic class operations
    localparam logic [1:0] OPC_AND  = 2'd0;
    localparam logic [1:0] OPC_ORR  = 2'd1;
    localparam logic [1:0] OPC_EOR  = 2'd2;
    localparam logic [1:0] OPC_ANDS = 2'd3;

    // Add/subtract class: bit 1 selects subtract, bit 0 sets flags
    localparam int OPC_SUB_BIT = 1;
    localparam int OPC_SET_BIT = 0;

    localparam logic [XLEN-1:0] MASK_W32 = {{(XLEN - HALF){1'b0}}, {HALF{1'b1}}};

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [1:0]        command;
        logic              wide;
        logic [1:0]        opc;
        logic              negate_second;
        logic [1:0]        shift_kind;
        logic [5:0]        shift_amount;
        logic [REG_AW-1:0] dest_reg;
        logic [REG_AW-1:0] first_reg;
        logic [REG_AW-1:0] second_reg;
        logic [REG_AW-1:0] addend_reg;
        logic              subtract_product;
    } t_item;

    typedef struct packed {
        logic [REG_AW-1:0] dest;
        logic              wide;
        logic              is_mac;
        logic              sub;
        logic              sets_flags;
        t_flags            flags;
        logic [XLEN-1:0]   result;
        logic [XLEN-1:0]   pp0;
        logic [HALF-1:0]   pp1;
        logic [HALF-1:0]   pp2;
        logic [XLEN-1:0]   ra;
    } t_exec;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_wr;

endpackage

FILE: hw/rtl/a64dp_cmd_if.sv
`timescale 1ns / 1ps

interface a64dp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       wide;
    logic [1:0] opc;
    logic       negate_second;
    logic [1:0] shift_kind;
    logic [5:0] shift_amount;
    logic [4:0] dest_reg;
    logic [4:0] first_reg;
    logic [4:0] second_reg;
    logic [4:0] addend_reg;
    logic       subtract_product;

    modport source (
        output valid, command, wide, opc, negate_second, shift_kind, shift_amount,
               dest_reg, first_reg, second_reg, addend_reg, subtract_product,
        input  ready
    );

    modport sink (
        input  valid, command, wide, opc, negate_second, shift_kind, shift_amount,
               dest_reg, first_reg, second_reg, addend_reg, subtract_product,
        output ready
    );
endinterface

FILE: hw/rtl/a64dp_res_if.sv
`timescale 1ns / 1ps

interface a64dp_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic        wrote_register;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;

    modport source (
        output valid, result_value, wrote_register, flag_n, flag_z, flag_c, flag_v,
        input  ready
    );

    modport sink (
        input  valid, result_value, wrote_register, flag_n, flag_z, flag_c, flag_v,
        output ready
    );
endinterface

FILE: hw/rtl/a64dp_regfile.sv
`timescale 1ns / 1ps

module a64dp_regfile
    import a64dp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [REG_AW-1:0]     i_rd_addr [3],
    input  t_wr                   i_wr,
    output logic [XLEN-1:0]       o_rd_data [3]
);

    // Two copies: copy A serves Rn and Rm, copy B serves Ra
    logic [XLEN-1:0]     r_mem_a [NUM_REGS];
    logic [XLEN-1:0]     r_mem_b [NUM_REGS];
    logic [NUM_REGS-1:0] r_written;
    logic [XLEN-1:0]     r_rd [3];
    logic [2:0]          r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.addr != ZERO_REG) begin
            r_mem_a[i_wr.addr] <= i_wr.data;
            r_mem_b[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_addr[0] != ZERO_REG) begin
            r_rd[0] <= r_mem_a[i_rd_addr[0]];
        end
        if (i_rd_addr[1] != ZERO_REG) begin
            r_rd[1] <= r_mem_a[i_rd_addr[1]];
        end
        if (i_rd_addr[2] != ZERO_REG) begin
            r_rd[2] <= r_mem_b[i_rd_addr[2]];
        end
    end

    // Entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= '0;
        end else begin
            if (i_wr.en && i_wr.addr != ZERO_REG) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                r_rd_ok[i] <= (i_rd_addr[i] != ZERO_REG) && r_written[i_rd_addr[i]];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_rd_data[i] = r_rd_ok[i] ? r_rd[i] : '0;
        end
    end

endmodule

FILE: hw/rtl/a64dp_alu.sv
`timescale 1ns / 1ps

module a64dp_alu
    import a64dp_pkg::*;
(
    input  t_item           i_item,
    input  logic [XLEN-1:0] i_rn,
    input  logic [XLEN-1:0] i_rm,
    input  logic [XLEN-1:0] i_ra,
    output t_exec           o_exec
);

    logic [XLEN-1:0]   mask;
    logic [5:0]        amt;
    logic [XLEN-1:0]   rn;
    logic [XLEN-1:0]   rm;
    logic [XLEN-1:0]   sx;
    logic [2*XLEN-1:0] ror_src;
    logic [2*XLEN-1:0] ror_out;
    logic [XLEN-1:0]   shifted;
    logic [XLEN-1:0]   lop;
    logic [XLEN-1:0]   logic_res;
    logic [XLEN-1:0]   aop;
    logic [XLEN:0]     sum;
    logic [XLEN-1:0]   add_res;
    logic [XLEN-1:0]   ovf;
    logic              is_logic;
    logic              is_addsub;
    logic              sub;
    t_flags            logic_flags;
    t_flags            add_flags;

    always_comb begin
        mask = i_item.wide ? '1 : MASK_W32;
        amt  = i_item.wide ? i_item.shift_amount : {1'b0, i_item.shift_amount[4:0]};
        rn   = i_rn & mask;
        rm   = i_rm & mask;

        // Shifter on Rm; a zero distance passes Rm through in every kind
        sx      = i_item.wide ? rm : {{(XLEN - HALF){rm[HALF-1]}}, rm[HALF-1:0]};
        ror_src = i_item.wide ? {rm, rm} : {{XLEN{1'b0}}, rm[HALF-1:0], rm[HALF-1:0]};
        ror_out = ror_src >> amt;
        case (i_item.shift_kind)
            SH_LSL:  shifted = (rm << amt) & mask;
            SH_LSR:  shifted = rm >> amt;
            SH_ASR:  shifted = XLEN'($signed(sx) >>> amt) & mask;
            SH_ROR:  shifted = ror_out[XLEN-1:0] & mask;
            default: shifted = rm;
        endcase

        // Bit logic
        lop = i_item.negate_second ? (~shifted & mask) : shifted;
        case (i_item.opc)
            OPC_AND:  logic_res = rn & lop;
            OPC_ORR:  logic_res = rn | lop;
            OPC_EOR:  logic_res = rn ^ lop;
            OPC_ANDS: logic_res = rn & lop;
            default:  logic_res = rn & lop;
        endcase
        logic_flags.n = i_item.wide ? logic_res[XLEN-1] : logic_res[HALF-1];
        logic_flags.z = (logic_res == '0);
        logic_flags.c = 1'b0;
        logic_flags.v = 1'b0;

        // Add/subtract: subtract is add of the inverted operand plus one
        sub     = i_item.opc[OPC_SUB_BIT];
        aop     = sub ? (~shifted & mask) : shifted;
        sum     = {1'b0, rn} + {1'b0, aop} + (XLEN + 1)'(sub);
        add_res = sum[XLEN-1:0] & mask;
        ovf     = (rn ^ add_res) & (aop ^ add_res);
        add_flags.n = i_item.wide ? add_res[XLEN-1] : add_res[HALF-1];
        add_flags.z = (add_res == '0);
        add_flags.c = i_item.wide ? sum[XLEN] : sum[HALF];
        add_flags.v = i_item.wide ? ovf[XLEN-1] : ovf[HALF-1];

        is_logic  = (i_item.command == CMD_LOGIC);
        is_addsub = (i_item.command == CMD_ADDSUB);

        o_exec.dest   = i_item.dest_reg;
        o_exec.wide   = i_item.wide;
        o_exec.is_mac = !is_logic && !is_addsub;
        o_exec.sub    = i_item.subtract_product;
        o_exec.sets_flags = (is_logic && i_item.opc == OPC_ANDS)
                         || (is_addsub && i_item.opc[OPC_SET_BIT]);
        o_exec.flags  = is_logic ? logic_flags : add_flags;
        o_exec.result = is_logic ? logic_res : add_res;

        // Low half of the 64x64 product as three 32x32 partial products
        o_exec.pp0 = rn[HALF-1:0] * rm[HALF-1:0];
        o_exec.pp1 = rn[HALF-1:0] * rm[XLEN-1:HALF];
        o_exec.pp2 = rn[XLEN-1:HALF] * rm[HALF-1:0];
        o_exec.ra  = i_ra & mask;
    end

endmodule

FILE: hw/rtl/a64_data_processing_register_exec_unit.sv
`timescale 1ns / 1ps

// A64 data-processing (register) execute unit.
// i_cmd (sink) takes one decoded instruction per item: class, width, opcode,
// shift of Rm, and the Rd/Rn/Rm/Ra register indexes. o_res (source) returns
// one item per instruction: the value written to Rd (masked to the width),
// whether a register was written, and NZCV after the instruction.
// An item is moved when valid and ready are both high.
// Pipeline: operand read (registered register-file read), execute
// (shifter, logic, adder, 32x32 partial products), then a writeback stage
// that sums the multiply, updates the register file and flags and loads the
// output register. Throughput is one item per cycle while the receiver takes
// results. The one exception: an instruction that reads the destination of a
// multiply-accumulate directly ahead of it waits until that instruction leaves
// writeback, because the multiply sum is only formed in writeback.
// Results from the execute stage and the last write are forwarded, so
// back-to-back dependent instructions otherwise run at full rate.
// When the receiver holds o_res.ready low, the result holds and the stages
// behind it keep filling until each holds an item; then i_cmd.ready drops.
// Reset (synchronous, active low) empties the pipeline, clears NZCV and
// marks every register as zero; no clearing pass is needed.

module a64_data_processing_register_exec_unit
    import a64dp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    a64dp_cmd_if.sink    i_cmd,
    a64dp_res_if.source  o_res
);

    t_item           in_item;
    logic            in_go;

    logic            r_s1_valid;
    t_item           r_s1;
    logic            r_s2_valid;
    t_exec           r_s2;
    t_wr             r_wb;
    t_flags          r_flags;

    logic            r_out_valid;
    logic [XLEN-1:0] r_out_value;
    logic            r_out_wrote;
    t_flags          r_out_flags;

    logic [REG_AW-1:0] n_rd_addr [3];
    logic [XLEN-1:0]   rd_data   [3];
    logic [XLEN-1:0]   fwd       [3];
    logic [REG_AW-1:0] s1_src    [3];
    t_exec             s1_exec;
    t_wr               wr;

    logic            haz;
    logic            s2_go;
    logic            s1_go;
    logic [XLEN-1:0] s2_mask;
    logic [XLEN-1:0] s2_prod;
    logic [XLEN-1:0] s2_mac;
    logic [XLEN-1:0] s2_value;
    t_flags          s2_flags;

    assign in_item.command          = i_cmd.command;
    assign in_item.wide             = i_cmd.wide;
    assign in_item.opc              = i_cmd.opc;
    assign in_item.negate_second    = i_cmd.negate_second;
    assign in_item.shift_kind       = i_cmd.shift_kind;
    assign in_item.shift_amount     = i_cmd.shift_amount;
    assign in_item.dest_reg         = i_cmd.dest_reg;
    assign in_item.first_reg        = i_cmd.first_reg;
    assign in_item.second_reg       = i_cmd.second_reg;
    assign in_item.addend_reg       = i_cmd.addend_reg;
    assign in_item.subtract_product = i_cmd.subtract_product;

    // Pipeline flow: a stage advances when the one ahead drains and no MAC hazard holds
    always_comb begin
        s1_src[0] = r_s1.first_reg;
        s1_src[1] = r_s1.second_reg;
        s1_src[2] = r_s1.addend_reg;

        haz = r_s2_valid && r_s2.is_mac && (r_s2.dest != ZERO_REG)
           && ((r_s2.dest == s1_src[0]) || (r_s2.dest == s1_src[1])
            || (r_s2.dest == s1_src[2]));

        s2_go = r_s2_valid && (!r_out_valid || o_res.ready);
        s1_go = r_s1_valid && !haz && (!r_s2_valid || s2_go);
        i_cmd.ready = !r_s1_valid || s1_go;
        in_go = i_cmd.valid && i_cmd.ready;
    end

    // Re-read the held addresses every cycle so a waiting item sees all writes
    always_comb begin
        if (in_go) begin
            n_rd_addr[0] = in_item.first_reg;
            n_rd_addr[1] = in_item.second_reg;
            n_rd_addr[2] = in_item.addend_reg;
        end else begin
            n_rd_addr = s1_src;
        end
    end

    a64dp_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (n_rd_addr),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    // Forward: execute-stage result first, then the write of the last edge
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_s2_valid && !r_s2.is_mac && r_s2.dest != ZERO_REG
                && r_s2.dest == s1_src[i]) begin
                fwd[i] = r_s2.result;
            end else if (r_wb.en && r_wb.addr == s1_src[i]) begin
                fwd[i] = r_wb.data;
            end else begin
                fwd[i] = rd_data[i];
            end
        end
    end

    a64dp_alu u_alu (
        .i_item (r_s1),
        .i_rn   (fwd[0]),
        .i_rm   (fwd[1]),
        .i_ra   (fwd[2]),
        .o_exec (s1_exec)
    );

    // Writeback: finish the multiply-accumulate and pick the result
    always_comb begin
        s2_mask  = r_s2.wide ? '1 : MASK_W32;
        s2_prod  = r_s2.pp0 + {r_s2.pp1 + r_s2.pp2, {HALF{1'b0}}};
        s2_mac   = (r_s2.sub ? (r_s2.ra - s2_prod) : (r_s2.ra + s2_prod)) & s2_mask;
        s2_value = r_s2.is_mac ? s2_mac : r_s2.result;
        s2_flags = r_s2.sets_flags ? r_s2.flags : r_flags;

        wr.en   = s2_go && (r_s2.dest != ZERO_REG);
        wr.addr = r_s2.dest;
        wr.data = s2_value;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb.en     <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_go) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            r_wb.en   <= wr.en;
            r_wb.addr <= wr.addr;
            r_wb.data <= wr.data;
            if (s2_go) begin
                r_flags <= s2_flags;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1 <= in_item;
        end
        if (s1_go) begin
            r_s2 <= s1_exec;
        end
        if (s2_go) begin
            r_out_value <= s2_value;
            r_out_wrote <= (r_s2.dest != ZERO_REG);
            r_out_flags <= s2_flags;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_value   = r_out_value;
    assign o_res.wrote_register = r_out_wrote;
    assign o_res.flag_n         = r_out_flags.n;
    assign o_res.flag_z         = r_out_flags.z;
    assign o_res.flag_c         = r_out_flags.c;
    assign o_res.flag_v         = r_out_flags.v;

endmodule

FILE: tb/a64dp_result_checker.sv
`timescale 1ns / 1ps

module a64dp_result_checker
    import a64dp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    a64dp_cmd_if i_cmd,
    a64dp_res_if i_res,
    output int   o_error_count,
    output int   o_pending,
    output int   o_results_checked
);

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            wrote;
        t_flags          flags;
    } t_retire;

    logic [XLEN-1:0] model_gpr [0:NUM_REGS-1];
    t_flags          model_nzcv;
    t_retire         expected_retire [$];

    function automatic logic [XLEN-1:0] read_gpr(logic [REG_AW-1:0] idx,
                                                 logic [XLEN-1:0] mask);
        if (idx == ZERO_REG)
            return '0;
        return model_gpr[idx] & mask;
    endfunction

    // Shift Rm at the operating width; the distance wraps at the width.
    function automatic logic [XLEN-1:0] shift_operand(logic [XLEN-1:0] v, logic [1:0] kind,
                                                      logic [5:0] amt, logic wide);
        logic [5:0]      sh_amt;
        logic [HALF-1:0] half;
        logic [XLEN-1:0] twice;
        logic [XLEN-1:0] mask;
        mask   = wide ? '1 : MASK_W32;
        sh_amt = wide ? amt : {1'b0, amt[4:0]};
        v      = v & mask;
        if (sh_amt == 0)
            return v;
        case (kind)
            SH_LSL: return (v << sh_amt) & mask;
            SH_LSR: return v >> sh_amt;
            SH_ASR: begin
                if (wide)
                    return $signed(v) >>> sh_amt;
                half = $signed(v[HALF-1:0]) >>> sh_amt;
                return {{HALF{1'b0}}, half};
            end
            default: begin
                if (wide)
                    return (v >> sh_amt) | (v << (7'd64 - {1'b0, sh_amt}));
                twice = {v[HALF-1:0], v[HALF-1:0]} >> sh_amt;
                return {{HALF{1'b0}}, twice[HALF-1:0]};
            end
        endcase
    endfunction

    // Run one instruction on the shadow state and return what it retires.
    function automatic t_retire execute_instruction(t_item it);
        logic [XLEN-1:0] mask;
        logic [XLEN-1:0] rn;
        logic [XLEN-1:0] rm;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] res;
        logic [XLEN-1:0] prod;
        logic [XLEN:0]   total;
        logic [XLEN-1:0] ovf;
        logic            carry_in;
        t_retire         out;
        mask = it.wide ? '1 : MASK_W32;
        rn   = read_gpr(it.first_reg, mask);
        rm   = read_gpr(it.second_reg, mask);
        if (it.command == CMD_LOGIC) begin
            b = shift_operand(rm, it.shift_kind, it.shift_amount, it.wide);
            if (it.negate_second)
                b = ~b & mask;
            case (it.opc)
                OPC_AND: res = rn & b;
                OPC_ORR: res = rn | b;
                OPC_EOR: res = rn ^ b;
                default: begin
                    res = rn & b;
                    model_nzcv.n = it.wide ? res[XLEN-1] : res[HALF-1];
                    model_nzcv.z = (res == '0);
                    model_nzcv.c = 1'b0;
                    model_nzcv.v = 1'b0;
                end
            endcase
        end else if (it.command == CMD_ADDSUB) begin
            b        = shift_operand(rm, it.shift_kind, it.shift_amount, it.wide);
            carry_in = 1'b0;
            if (it.opc[OPC_SUB_BIT]) begin
                b        = ~b & mask;
                carry_in = 1'b1;
            end
            total = {1'b0, rn} + {1'b0, b} + {{XLEN{1'b0}}, carry_in};
            res   = total[XLEN-1:0] & mask;
            if (it.opc[OPC_SET_BIT]) begin
                ovf = (rn ^ res) & (b ^ res);
                model_nzcv.n = it.wide ? res[XLEN-1] : res[HALF-1];
                model_nzcv.z = (res == '0);
                model_nzcv.c = it.wide ? total[XLEN] : total[HALF];
                model_nzcv.v = it.wide ? ovf[XLEN-1] : ovf[HALF-1];
            end
        end else begin
            prod = rn * rm;
            if (it.subtract_product)
                res = (read_gpr(it.addend_reg, mask) - prod) & mask;
            else
                res = (read_gpr(it.addend_reg, mask) + prod) & mask;
        end
        if (it.dest_reg != ZERO_REG)
            model_gpr[it.dest_reg] = res;
        out.value = res;
        out.wrote = (it.dest_reg != ZERO_REG);
        out.flags = model_nzcv;
        return out;
    endfunction

    task automatic check_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
        if (want !== got) begin
            o_error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   seen;
        t_retire got;
        t_retire want;
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++)
                model_gpr[r] = '0;
            model_nzcv = '0;
            expected_retire.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.value   = i_res.result_value;
                got.wrote   = i_res.wrote_register;
                got.flags.n = i_res.flag_n;
                got.flags.z = i_res.flag_z;
                got.flags.c = i_res.flag_c;
                got.flags.v = i_res.flag_v;
                if (expected_retire.size() == 0) begin
                    o_error_count++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got.value);
                end else begin
                    want = expected_retire.pop_front();
                    check_field("result_value", want.value, got.value);
                    check_field("wrote_register", XLEN'(want.wrote), XLEN'(got.wrote));
                    check_field("flag_n", XLEN'(want.flags.n), XLEN'(got.flags.n));
                    check_field("flag_z", XLEN'(want.flags.z), XLEN'(got.flags.z));
                    check_field("flag_c", XLEN'(want.flags.c), XLEN'(got.flags.c));
                    check_field("flag_v", XLEN'(want.flags.v), XLEN'(got.flags.v));
                    o_results_checked++;
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                seen.command          = i_cmd.command;
                seen.wide             = i_cmd.wide;
                seen.opc              = i_cmd.opc;
                seen.negate_second    = i_cmd.negate_second;
                seen.shift_kind       = i_cmd.shift_kind;
                seen.shift_amount     = i_cmd.shift_amount;
                seen.dest_reg         = i_cmd.dest_reg;
                seen.first_reg        = i_cmd.first_reg;
                seen.second_reg       = i_cmd.second_reg;
                seen.addend_reg       = i_cmd.addend_reg;
                seen.subtract_product = i_cmd.subtract_product;
                expected_retire.push_back(execute_instruction(seen));
            end
        end
        o_pending = expected_retire.size();
    end

endmodule

FILE: tb/a64_data_processing_register_exec_unit_test.sv
`timescale 1ns / 1ps

module a64_data_processing_register_exec_unit_test
    import a64dp_pkg::*;
();

    // Class and opcode names that the package leaves as bare bits.
    localparam logic [1:0] CMD_MULACC = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;   // decodes as multiply-accumulate
    localparam logic [1:0] OPC_ADD    = 2'd0;
    localparam logic [1:0] OPC_ADDS   = 2'd1;
    localparam logic [1:0] OPC_SUB    = 2'd2;
    localparam logic [1:0] OPC_SUBS   = 2'd3;
    localparam logic       W64        = 1'b1;
    localparam logic       W32        = 1'b0;

    localparam int ITEMS_PER_PHASE   = 300;
    localparam int NUM_PHASES        = 4;
    localparam int LONG_STALL_CYCLES = 60;
    localparam int TAIL_CYCLES       = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    a64dp_cmd_if cmd_bus ();
    a64dp_res_if res_bus ();

    int   error_count;
    int   pending;
    int   results_checked;
    int   items_sent      = 0;
    int   send_idle_pct   = 0;
    int   stall_pct       = 0;
    logic hold_off        = 1'b0;
    event long_stall_go;

    a64_data_processing_register_exec_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    a64dp_result_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd_bus),
        .i_res             (res_bus),
        .o_error_count     (error_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: stall at the current rate, and hold off entirely while a long
    // stall is in progress.
    always @(posedge i_clk) begin
        res_bus.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Long stall: count the cycles here so the sender keeps offering items
    // meanwhile and the pipeline backs up into i_cmd.ready.
    initial begin
        forever begin
            @(long_stall_go);
            hold_off <= 1'b1;
            repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_item make_op(logic [1:0] command, logic wide, logic [1:0] opc,
                                      logic neg, logic [1:0] kind, logic [5:0] amt,
                                      logic [4:0] rd, logic [4:0] rn, logic [4:0] rm,
                                      logic [4:0] ra, logic sub_prod);
        t_item it;
        it.command          = command;
        it.wide             = wide;
        it.opc              = opc;
        it.negate_second    = neg;
        it.shift_kind       = kind;
        it.shift_amount     = amt;
        it.dest_reg         = rd;
        it.first_reg        = rn;
        it.second_reg       = rm;
        it.addend_reg       = ra;
        it.subtract_product = sub_prod;
        return it;
    endfunction

    // Favor a few registers so results feed the next instructions back to
    // back; still reach every index, the zero register included.
    function automatic logic [4:0] pick_register();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 5'($urandom_range(7));
        if (roll < 70)
            return ZERO_REG;
        return 5'($urandom_range(31));
    endfunction

    // Mix zero, the width boundaries and uniform distances.
    function automatic logic [5:0] pick_distance();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return 6'd0;
        if (roll < 45) begin
            case ($urandom_range(3))
                0:       return 6'd1;
                1:       return 6'd31;
                2:       return 6'd32;
                default: return 6'd63;
            endcase
        end
        return 6'($urandom_range(63));
    endfunction

    function automatic t_item random_instruction();
        return make_op(2'($urandom_range(3)), 1'($urandom_range(1)), 2'($urandom_range(3)),
                       1'($urandom_range(1)), 2'($urandom_range(3)), pick_distance(),
                       pick_register(), pick_register(), pick_register(), pick_register(),
                       1'($urandom_range(1)));
    endfunction

    // Offer one item after a random idle gap and hold it until accepted.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid            <= 1'b1;
        cmd_bus.command          <= it.command;
        cmd_bus.wide             <= it.wide;
        cmd_bus.opc              <= it.opc;
        cmd_bus.negate_second    <= it.negate_second;
        cmd_bus.shift_kind       <= it.shift_kind;
        cmd_bus.shift_amount     <= it.shift_amount;
        cmd_bus.dest_reg         <= it.dest_reg;
        cmd_bus.first_reg        <= it.first_reg;
        cmd_bus.second_reg       <= it.second_reg;
        cmd_bus.addend_reg       <= it.addend_reg;
        cmd_bus.subtract_product <= it.subtract_product;
        @(posedge i_clk);
        while (!cmd_bus.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic wait_for_drain();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        // Park every input at a known value before reset.
        cmd_bus.valid            <= 1'b0;
        cmd_bus.command          <= '0;
        cmd_bus.wide             <= 1'b0;
        cmd_bus.opc              <= '0;
        cmd_bus.negate_second    <= 1'b0;
        cmd_bus.shift_kind       <= '0;
        cmd_bus.shift_amount     <= '0;
        cmd_bus.dest_reg         <= '0;
        cmd_bus.first_reg        <= '0;
        cmd_bus.second_reg       <= '0;
        cmd_bus.addend_reg       <= '0;
        cmd_bus.subtract_product <= 1'b0;
        i_rst_n                  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners. Registers start at zero, so build values first:
        // all ones from ORN of the zero register, then single bits from shifts.
        send_item(make_op(CMD_LOGIC, W64, OPC_ORR, 1, SH_LSL, 0, 0, ZERO_REG, ZERO_REG, 0, 0));
        send_item(make_op(CMD_LOGIC, W32, OPC_ORR, 1, SH_LSL, 0, 1, ZERO_REG, ZERO_REG, 0, 0));
        send_item(make_op(CMD_ADDSUB, W64, OPC_ADD, 0, SH_LSR, 63, 2, ZERO_REG, 0, 0, 0));
        send_item(make_op(CMD_ADDSUB, W64, OPC_ADD, 0, SH_LSL, 63, 3, ZERO_REG, 0, 0, 0));
        // Signed overflow on subtract, carry and zero on add, both widths.
        send_item(make_op(CMD_ADDSUB, W64, OPC_SUBS, 0, SH_LSL, 0, 4, 3, 2, 0, 0));
        send_item(make_op(CMD_ADDSUB, W64, OPC_ADDS, 0, SH_LSL, 0, 5, 3, 3, 0, 0));
        send_item(make_op(CMD_ADDSUB, W32, OPC_ADDS, 0, SH_LSL, 0, 6, 1, 2, 0, 0));
        send_item(make_op(CMD_ADDSUB, W32, OPC_SUBS, 0, SH_LSL, 0, 7, ZERO_REG, 2, 0, 0));
        // Every shift kind, a zero distance, and a distance past the 32-bit width.
        send_item(make_op(CMD_LOGIC, W64, OPC_ORR, 0, SH_ASR, 63, 8, ZERO_REG, 3, 0, 0));
        send_item(make_op(CMD_LOGIC, W32, OPC_ORR, 0, SH_ROR, 1, 9, ZERO_REG, 2, 0, 0));
        send_item(make_op(CMD_LOGIC, W64, OPC_EOR, 0, SH_ROR, 0, 10, 2, 4, 0, 0));
        send_item(make_op(CMD_LOGIC, W32, OPC_ORR, 0, SH_LSL, 63, 11, ZERO_REG, 1, 0, 0));
        // Flag-setting logic, and the inverted forms BIC, EON.
        send_item(make_op(CMD_LOGIC, W64, OPC_ANDS, 0, SH_LSL, 0, 12, 0, 3, 0, 0));
        send_item(make_op(CMD_LOGIC, W32, OPC_ANDS, 1, SH_LSL, 0, 13, 1, 1, 0, 0));
        send_item(make_op(CMD_LOGIC, W64, OPC_AND, 1, SH_LSL, 0, 14, 0, 2, 0, 0));
        send_item(make_op(CMD_LOGIC, W64, OPC_EOR, 1, SH_LSR, 4, 15, 4, 3, 0, 0));
        // ROR on the add/subtract path.
        send_item(make_op(CMD_ADDSUB, W64, OPC_SUB, 0, SH_ROR, 32, 16, 0, 3, 0, 0));
        // Multiply-accumulate, then an instruction reading its destination.
        send_item(make_op(CMD_MULACC, W64, OPC_ADD, 0, SH_LSL, 0, 17, 4, 4, 2, 0));
        send_item(make_op(CMD_ADDSUB, W64, OPC_ADD, 0, SH_LSL, 0, 18, 17, 17, 0, 0));
        send_item(make_op(CMD_MULACC, W32, OPC_ADD, 0, SH_LSL, 0, 19, 1, 1, ZERO_REG, 1));
        send_item(make_op(CMD_SPARE, W64, OPC_ADD, 0, SH_LSL, 0, 20, 4, 0, 3, 0));
        // Discarded destination still updates the flags.
        send_item(make_op(CMD_ADDSUB, W64, OPC_ADDS, 0, SH_LSL, 0, ZERO_REG, 0, 2, 0, 0));
        // Fields that the class ignores.
        send_item(make_op(CMD_ADDSUB, W64, OPC_ADD, 1, SH_LSL, 0, 21, 2, 2, 0, 0));
        send_item(make_op(CMD_LOGIC, W64, OPC_AND, 0, SH_LSL, 0, 22, 0, 4, 0, 1));
        wait_for_drain();

        // Random instructions under each handshake mix; drain between phases.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    -> long_stall_go;
                end
                1: begin
                    send_idle_pct = 78;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 78;
                end
                default: begin
                    send_idle_pct = 35;
                    stall_pct     = 35;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_item(random_instruction());
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d instructions: directed corners of all classes and shifts,",
                 items_sent);
        $display("then random mixes under four idle and stall patterns; %0d results compared.",
                 results_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
